// ===== hw/rtl/pwts_pkg.sv =====
// Shared types and constants of the perspective world-to-screen projection pipeline.
package pwts_pkg;

    localparam int COEF_FRAC_BITS  = 12;
    localparam int COORD_FRAC_BITS = 8;
    localparam int OUT_FRAC_BITS   = 8;
    localparam int SUM_FRAC_BITS   = COEF_FRAC_BITS + COORD_FRAC_BITS;
    localparam int HID_SHIFT       = SUM_FRAC_BITS - OUT_FRAC_BITS;
    localparam longint NEAR_LIMIT  = ((longint'(1) << SUM_FRAC_BITS) + 500) / 1000;
    localparam int HIDDEN_GAIN     = 100000;

    localparam int COEF_W  = 16;
    localparam int PT_W    = 24;
    localparam int ROW_W   = 64;
    localparam int SIZE_W  = 14;
    localparam int SUM_W   = 42;   // dot product
    localparam int NUM_W   = 43;   // w + clip, multiplier operand
    localparam int GAIN_W  = 21;   // viewport gain or hidden gain
    localparam int MLO_W   = 22;   // low part of split multiply
    localparam int PART_W  = 43;   // partial products
    localparam int MUL_W   = 64;   // full product
    localparam int NUMD_W  = 66;   // 2*prod + w
    localparam int HID_W   = 65;   // rounded hidden value before clamp
    localparam int DIV_W   = 43;   // divisor 2*w
    localparam int REM_W   = 76;   // divider remainder
    localparam int REMS_W  = 77;   // offset numerator, signed
    localparam int Q_W     = 33;   // divider quotient
    localparam int OUT_W   = 32;
    localparam int IDX_W   = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_ROW_X  = 3'd0,
        REG_ROW_Y  = 3'd1,
        REG_ROW_W  = 3'd2,
        REG_WIDTH  = 3'd3,
        REG_HEIGHT = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic signed [PT_W-1:0] point_x;
        logic signed [PT_W-1:0] point_y;
        logic signed [PT_W-1:0] point_z;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] screen_x;
        logic signed [OUT_W-1:0] screen_y;
        logic                    visible;
        logic                    saturated;
    } t_out;

    typedef struct packed {
        logic [ROW_W-1:0]  row_x;
        logic [ROW_W-1:0]  row_y;
        logic [ROW_W-1:0]  row_w;
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
    } t_cfg;

    typedef struct packed {
        logic signed [NUM_W-1:0] m_x;
        logic signed [NUM_W-1:0] m_y;
        logic [GAIN_W-1:0]       g_x;
        logic [GAIN_W-1:0]       g_y;
        logic signed [SUM_W-1:0] w;
        logic                    vis;
    } t_mul;

    typedef struct packed {
        logic [REM_W-1:0]        rem_x;
        logic [REM_W-1:0]        rem_y;
        logic [REM_W-1:0]        ds;
        logic [Q_W-1:0]          q_x;
        logic [Q_W-1:0]          q_y;
        logic                    lo_x;
        logic                    hi_x;
        logic                    lo_y;
        logic                    hi_y;
        logic                    vis;
        logic signed [OUT_W-1:0] hid_x;
        logic signed [OUT_W-1:0] hid_y;
        logic                    hsat_x;
        logic                    hsat_y;
    } t_div;

endpackage

// ===== hw/rtl/pwts_front.sv =====
// Dot products of the point with three matrix rows, near test and multiplier operand select.
module pwts_front import pwts_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_valid,
    input  t_in  i_item,
    output logic o_stall,
    output logic o_valid,
    output t_mul o_mul,
    input  logic i_stall
);

    logic signed [SUM_W-1:0] r_p [3][3];
    logic signed [SUM_W-1:0] n_p [3][3];
    logic signed [SUM_W-1:0] r_k [3];
    logic signed [SUM_W-1:0] n_k [3];
    logic signed [SUM_W-1:0] r_s [3];
    logic signed [SUM_W-1:0] n_s [3];
    t_mul r_o, n_o;
    logic [2:0] r_v;
    logic [2:0] en;
    logic [ROW_W-1:0] rows [3];
    logic signed [SUM_W-1:0] pts [3];
    logic signed [NUM_W-1:0] nx, ny;

    assign en[2]   = !r_v[2] || !i_stall;
    assign en[1]   = !r_v[1] || en[2];
    assign en[0]   = !r_v[0] || en[1];
    assign o_stall = !en[0];
    assign o_valid = r_v[2];
    assign o_mul   = r_o;

    always_comb begin
        rows[0] = i_cfg.row_x;
        rows[1] = i_cfg.row_y;
        rows[2] = i_cfg.row_w;
        pts[0]  = SUM_W'(i_item.point_x);
        pts[1]  = SUM_W'(i_item.point_y);
        pts[2]  = SUM_W'(i_item.point_z);
        for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 3; j++) begin
                n_p[r][j] = SUM_W'($signed(rows[r][COEF_W*j +: COEF_W])) * pts[j];
            end
            n_k[r] = SUM_W'($signed(rows[r][COEF_W*3 +: COEF_W])) <<< COORD_FRAC_BITS;
            n_s[r] = r_p[r][0] + r_p[r][1] + r_p[r][2] + r_k[r];
        end
    end

    always_comb begin
        n_o.w   = r_s[2];
        n_o.vis = r_s[2] >= SUM_W'(NEAR_LIMIT);
        nx      = NUM_W'(r_s[2]) + NUM_W'(r_s[0]);
        ny      = NUM_W'(r_s[2]) - NUM_W'(r_s[1]);
        if (n_o.vis) begin
            n_o.m_x = nx;
            n_o.m_y = ny;
            n_o.g_x = GAIN_W'(i_cfg.width) << (OUT_FRAC_BITS - 1);
            n_o.g_y = GAIN_W'(i_cfg.height) << (OUT_FRAC_BITS - 1);
        end else begin
            n_o.m_x = NUM_W'(r_s[0]);
            n_o.m_y = NUM_W'(r_s[1]);
            n_o.g_x = GAIN_W'(HIDDEN_GAIN);
            n_o.g_y = GAIN_W'(HIDDEN_GAIN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            if (en[1]) r_v[1] <= r_v[0];
            if (en[2]) r_v[2] <= r_v[1];
        end
        if (en[0]) begin
            r_p <= n_p;
            r_k <= n_k;
        end
        if (en[1]) r_s <= n_s;
        if (en[2]) r_o <= n_o;
    end

endmodule

// ===== hw/rtl/pwts_mul.sv =====
// Split viewport/hidden gain multiply, rounding of hidden values and divider setup.
module pwts_mul import pwts_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_mul i_mul,
    output logic o_stall,
    output logic o_valid,
    output t_div o_div,
    input  logic i_stall
);

    localparam logic signed [HID_W-1:0] H_MAX = HID_W'(64'sd2147483647);
    localparam logic signed [HID_W-1:0] H_MIN = HID_W'(-64'sd2147483648);
    localparam logic signed [HID_W-1:0] H_HALF = HID_W'(1) <<< (HID_SHIFT - 1);

    logic [4:0] r_v;
    logic [4:0] en;

    logic signed [NUM_W-1:0] m [2];
    logic [GAIN_W-1:0]       g [2];

    logic [PART_W-1:0]        r_a_plo [2];
    logic signed [PART_W-1:0] r_a_phi [2];
    logic signed [SUM_W-1:0]  r_a_w;
    logic                     r_a_vis;

    logic signed [MUL_W-1:0]  r_b_prod [2];
    logic signed [SUM_W-1:0]  r_b_w;
    logic                     r_b_vis;

    logic signed [NUMD_W-1:0] r_c_num [2];
    logic signed [HID_W-1:0]  r_c_hid [2];
    logic [DIV_W-1:0]         r_c_d;
    logic                     r_c_vis;

    logic signed [REMS_W-1:0] r_d_rem [2];
    logic signed [OUT_W-1:0]  r_d_hid [2];
    logic                     r_d_hsat [2];
    logic [DIV_W-1:0]         r_d_d;
    logic                     r_d_vis;

    t_div r_e, n_e;

    always_comb begin
        en[4] = !r_v[4] || !i_stall;
        for (int k = 3; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_v[4];
    assign o_div   = r_e;

    assign m[0] = i_mul.m_x;
    assign m[1] = i_mul.m_y;
    assign g[0] = i_mul.g_x;
    assign g[1] = i_mul.g_y;

    always_comb begin
        n_e.rem_x = r_d_rem[0][REM_W-1:0];
        n_e.rem_y = r_d_rem[1][REM_W-1:0];
        n_e.ds    = {1'b0, r_d_d, 32'b0};
        n_e.q_x   = '0;
        n_e.q_y   = '0;
        n_e.lo_x  = r_d_rem[0][REMS_W-1];
        n_e.lo_y  = r_d_rem[1][REMS_W-1];
        n_e.hi_x  = !r_d_rem[0][REMS_W-1] && (r_d_rem[0][REM_W-1:0] >= {r_d_d, 33'b0});
        n_e.hi_y  = !r_d_rem[1][REMS_W-1] && (r_d_rem[1][REM_W-1:0] >= {r_d_d, 33'b0});
        n_e.vis   = r_d_vis;
        n_e.hid_x = r_d_hid[0];
        n_e.hid_y = r_d_hid[1];
        n_e.hsat_x = r_d_hsat[0];
        n_e.hsat_y = r_d_hsat[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < 5; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
        if (en[0]) begin
            for (int l = 0; l < 2; l++) begin
                r_a_plo[l] <= PART_W'(m[l][MLO_W-1:0]) * PART_W'(g[l]);
                r_a_phi[l] <= PART_W'($signed(m[l][NUM_W-1:MLO_W]))
                              * $signed(PART_W'(g[l]));
            end
            r_a_w   <= i_mul.w;
            r_a_vis <= i_mul.vis;
        end
        if (en[1]) begin
            for (int l = 0; l < 2; l++) begin
                r_b_prod[l] <= (MUL_W'(r_a_phi[l]) <<< MLO_W)
                               + MUL_W'($signed({1'b0, r_a_plo[l]}));
            end
            r_b_w   <= r_a_w;
            r_b_vis <= r_a_vis;
        end
        if (en[2]) begin
            for (int l = 0; l < 2; l++) begin
                r_c_num[l] <= (NUMD_W'(r_b_prod[l]) <<< 1) + NUMD_W'(r_b_w);
                r_c_hid[l] <= (HID_W'(r_b_prod[l]) + H_HALF) >>> HID_SHIFT;
            end
            r_c_d   <= DIV_W'(r_b_w[SUM_W-2:0]) << 1;
            r_c_vis <= r_b_vis;
        end
        if (en[3]) begin
            for (int l = 0; l < 2; l++) begin
                // offset by 2^32 divisors so the quotient is non-negative
                r_d_rem[l] <= REMS_W'(r_c_num[l]) + $signed({2'b0, r_c_d, 32'b0});
                if (r_c_hid[l] > H_MAX) begin
                    r_d_hid[l]  <= OUT_W'(H_MAX);
                    r_d_hsat[l] <= 1'b1;
                end else if (r_c_hid[l] < H_MIN) begin
                    r_d_hid[l]  <= OUT_W'(H_MIN);
                    r_d_hsat[l] <= 1'b1;
                end else begin
                    r_d_hid[l]  <= OUT_W'(r_c_hid[l]);
                    r_d_hsat[l] <= 1'b0;
                end
            end
            r_d_d   <= r_c_d;
            r_d_vis <= r_c_vis;
        end
        if (en[4]) r_e <= n_e;
    end

endmodule

// ===== hw/rtl/pwts_div_step.sv =====
// One restoring division step for both screen axes, one quotient bit per stage.
module pwts_div_step import pwts_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_div i_div,
    output logic o_stall,
    output logic o_valid,
    output t_div o_div,
    input  logic i_stall
);

    logic r_v;
    logic en;
    t_div r_d, n_d;

    assign en      = !r_v || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_v;
    assign o_div   = r_d;

    always_comb begin
        n_d    = i_div;
        n_d.ds = i_div.ds >> 1;
        if (i_div.rem_x >= i_div.ds) begin
            n_d.rem_x = i_div.rem_x - i_div.ds;
            n_d.q_x   = {i_div.q_x[Q_W-2:0], 1'b1};
        end else begin
            n_d.q_x   = {i_div.q_x[Q_W-2:0], 1'b0};
        end
        if (i_div.rem_y >= i_div.ds) begin
            n_d.rem_y = i_div.rem_y - i_div.ds;
            n_d.q_y   = {i_div.q_y[Q_W-2:0], 1'b1};
        end else begin
            n_d.q_y   = {i_div.q_y[Q_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_valid;
        end
        if (en) r_d <= n_d;
    end

endmodule

// ===== hw/rtl/perspective_world_to_screen.sv =====
// Top level of the perspective world-to-screen projection pipeline.
// Projects one Q16.8 world point per cycle to Q24.8 screen coordinates while the output is
// not stalled. Each point passes through the matrix dot products and near test, the split
// gain multiply and divider setup, the restoring divider (one quotient bit per stage) and
// an output register. A stalled output holds the
// item while earlier stages keep filling bubbles. Registers are written through the
// plain write port; index 0..2 are the clip x, clip y and w rows, 3 and 4 are the
// viewport width and height, other indexes are ignored.
module perspective_world_to_screen import pwts_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wen,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [ROW_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in               i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out              o_out_item
);

    localparam int STEPS = Q_W;
    localparam logic signed [Q_W:0] Q_OFS = (Q_W+1)'(1) <<< 32;
    localparam logic signed [Q_W:0] Q_MAX = (Q_W+1)'(32'sh7fffffff);
    localparam logic signed [Q_W:0] Q_MIN = -((Q_W+1)'(1) <<< 31);

    t_cfg r_cfg;
    t_mul w_mul;
    logic w_mul_valid, w_mul_stall;
    t_div w_div [STEPS+1];
    logic w_v [STEPS+1];
    logic w_stall [STEPS+1];
    logic r_out_v;
    t_out r_out, n_out;
    logic en_out;
    logic signed [Q_W:0] qs [2];
    logic [Q_W-1:0] qq [2];
    logic lo [2], hi [2], hsat [2], sat [2];
    logic signed [OUT_W-1:0] hid [2], res [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_x  <= '0;
            r_cfg.row_y  <= '0;
            r_cfg.row_w  <= '0;
            r_cfg.width  <= SIZE_W'(1920);
            r_cfg.height <= SIZE_W'(1080);
        end else if (i_cfg_wen) begin
            case (t_reg_idx'(i_cfg_index))
                REG_ROW_X:  r_cfg.row_x  <= i_cfg_data;
                REG_ROW_Y:  r_cfg.row_y  <= i_cfg_data;
                REG_ROW_W:  r_cfg.row_w  <= i_cfg_data;
                REG_WIDTH:  r_cfg.width  <= i_cfg_data[SIZE_W-1:0];
                REG_HEIGHT: r_cfg.height <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    pwts_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .o_stall (o_in_stall),
        .o_valid (w_mul_valid),
        .o_mul   (w_mul),
        .i_stall (w_mul_stall)
    );

    pwts_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mul_valid),
        .i_mul   (w_mul),
        .o_stall (w_mul_stall),
        .o_valid (w_v[0]),
        .o_div   (w_div[0]),
        .i_stall (w_stall[0])
    );

    for (genvar k = 0; k < STEPS; k++) begin : g_div
        pwts_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[k]),
            .i_div   (w_div[k]),
            .o_stall (w_stall[k]),
            .o_valid (w_v[k+1]),
            .o_div   (w_div[k+1]),
            .i_stall (w_stall[k+1])
        );
    end

    assign en_out          = !r_out_v || !i_out_stall;
    assign w_stall[STEPS]  = !en_out;

    always_comb begin
        qq[0]   = w_div[STEPS].q_x;
        qq[1]   = w_div[STEPS].q_y;
        lo[0]   = w_div[STEPS].lo_x;
        lo[1]   = w_div[STEPS].lo_y;
        hi[0]   = w_div[STEPS].hi_x;
        hi[1]   = w_div[STEPS].hi_y;
        hid[0]  = w_div[STEPS].hid_x;
        hid[1]  = w_div[STEPS].hid_y;
        hsat[0] = w_div[STEPS].hsat_x;
        hsat[1] = w_div[STEPS].hsat_y;
        for (int l = 0; l < 2; l++) begin
            // remove the 2^32 offset added before division
            qs[l] = $signed({1'b0, qq[l]}) - Q_OFS;
            if (!w_div[STEPS].vis) begin
                res[l] = hid[l];
                sat[l] = hsat[l];
            end else if (lo[l] || qs[l] < Q_MIN) begin
                res[l] = OUT_W'(Q_MIN);
                sat[l] = 1'b1;
            end else if (hi[l] || qs[l] > Q_MAX) begin
                res[l] = OUT_W'(Q_MAX);
                sat[l] = 1'b1;
            end else begin
                res[l] = OUT_W'(qs[l]);
                sat[l] = 1'b0;
            end
        end
        n_out.screen_x  = res[0];
        n_out.screen_y  = res[1];
        n_out.visible   = w_div[STEPS].vis;
        n_out.saturated = sat[0] || sat[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en_out) begin
            r_out_v <= w_v[STEPS];
        end
        if (en_out) r_out <= n_out;
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

endmodule

// ===== sim/perspective_world_to_screen_tb.sv =====
// Self-checking testbench for the perspective world-to-screen projection pipeline.
module perspective_world_to_screen_tb;
    import pwts_pkg::*;

    localparam logic [IDX_W-1:0] IDX_UNUSED = 3'd5;
    localparam longint MAX32 = 64'sd2147483647;
    localparam longint MIN32 = -64'sd2147483648;
    localparam longint QUOT_LIM = longint'(1) << 33;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 60;
    localparam int LONG_HOLD = 300;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wen;
    logic [IDX_W-1:0] i_cfg_index;
    logic [ROW_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_stall;
    t_in              i_in_item;
    logic             o_out_valid;
    logic             i_out_stall;
    t_out             o_out_item;

    perspective_world_to_screen dut (.*);

    // predictor copy of the registers
    logic [ROW_W-1:0]  cur_row_x, cur_row_y, cur_row_w;
    logic [SIZE_W-1:0] cur_width, cur_height;

    t_in  pending_points[$];
    t_out expected_pixels[$];
    int   n_in, n_out, n_hidden, n_sat, n_err;
    int   src_gap, sink_gap, hold_left, idle_cycles;
    bit   hold_done, quiet;

    function automatic longint row_dot(logic [ROW_W-1:0] row, longint px, longint py,
                                       longint pz);
        return longint'($signed(row[15:0])) * px + longint'($signed(row[31:16])) * py
             + longint'($signed(row[47:32])) * pz
             + longint'($signed(row[63:48])) * (longint'(1) << COORD_FRAC_BITS);
    endfunction

    // round(size * 128 * n / w), w > 0, ties upward
    function automatic longint scale_to_view(longint n, longint w, logic [SIZE_W-1:0] size);
        longint a, q, r, f;
        a = longint'(size) << (OUT_FRAC_BITS - 1);
        q = n / w;
        r = n % w;
        if (r < 0) begin
            r += w;
            q -= 1;
        end
        if (a == 0) return 0;
        if (q > QUOT_LIM) return longint'(1) << 40;
        if (q < -QUOT_LIM) return -(longint'(1) << 40);
        // all terms are non-negative and stay well below 2^63
        f = (longint'(2) * a * r + w) / (longint'(2) * w);
        return a * q + f;
    endfunction

    function automatic t_out project_point(t_in p);
        longint px, py, pz, cx, cy, w, sx, sy;
        t_out r;
        px = p.point_x;
        py = p.point_y;
        pz = p.point_z;
        cx = row_dot(cur_row_x, px, py, pz);
        cy = row_dot(cur_row_y, px, py, pz);
        w  = row_dot(cur_row_w, px, py, pz);
        r.saturated = 1'b0;
        if (w < NEAR_LIMIT) begin
            r.visible = 1'b0;
            sx = (cx * HIDDEN_GAIN + (longint'(1) << (HID_SHIFT - 1))) >>> HID_SHIFT;
            sy = (cy * HIDDEN_GAIN + (longint'(1) << (HID_SHIFT - 1))) >>> HID_SHIFT;
        end else begin
            r.visible = 1'b1;
            sx = scale_to_view(w + cx, w, cur_width);
            sy = scale_to_view(w - cy, w, cur_height);
        end
        if (sx > MAX32) begin sx = MAX32; r.saturated = 1'b1; end
        if (sx < MIN32) begin sx = MIN32; r.saturated = 1'b1; end
        if (sy > MAX32) begin sy = MAX32; r.saturated = 1'b1; end
        if (sy < MIN32) begin sy = MIN32; r.saturated = 1'b1; end
        r.screen_x = sx[31:0];
        r.screen_y = sy[31:0];
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_pixels.push_back(project_point(i_in_item));
                n_in++;
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_points.size() > 0) begin
                    if (!quiet && $urandom_range(0, 9) == 0) begin
                        src_gap = $urandom_range(0, 18);
                        i_in_valid <= 1'b0;
                    end else begin
                        i_in_valid <= 1'b1;
                        i_in_item <= pending_points.pop_front();
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor and stall generator
    always @(posedge i_clk) begin
        t_out e;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                n_out++;
                if (expected_pixels.size() == 0) begin
                    $error("unexpected item: screen_x %0d screen_y %0d",
                           o_out_item.screen_x, o_out_item.screen_y);
                    n_err++;
                end else begin
                    e = expected_pixels.pop_front();
                    if (!e.visible) n_hidden++;
                    if (e.saturated) n_sat++;
                    if (o_out_item.screen_x !== e.screen_x) begin
                        $error("screen_x expected %0d actual %0d", e.screen_x,
                               o_out_item.screen_x);
                        n_err++;
                    end
                    if (o_out_item.screen_y !== e.screen_y) begin
                        $error("screen_y expected %0d actual %0d", e.screen_y,
                               o_out_item.screen_y);
                        n_err++;
                    end
                    if (o_out_item.visible !== e.visible) begin
                        $error("visible expected %0d actual %0d", e.visible,
                               o_out_item.visible);
                        n_err++;
                    end
                    if (o_out_item.saturated !== e.saturated) begin
                        $error("saturated expected %0d actual %0d", e.saturated,
                               o_out_item.saturated);
                        n_err++;
                    end
                end
            end
            // hold off once for a long stretch so the pipeline backs up
            if (!hold_done && n_in >= 300) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (sink_gap > 0) begin
                sink_gap--;
                i_out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                sink_gap = $urandom_range(0, 18);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [ROW_W-1:0] data);
        @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            REG_ROW_X:  cur_row_x = data;
            REG_ROW_Y:  cur_row_y = data;
            REG_ROW_W:  cur_row_w = data;
            REG_WIDTH:  cur_width = data[SIZE_W-1:0];
            REG_HEIGHT: cur_height = data[SIZE_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
    endtask

    // sample after the edge has settled so a just-popped item is not missed
    task automatic drain;
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_points.size() > 0 || i_in_valid || expected_pixels.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_point(logic [PT_W-1:0] x, logic [PT_W-1:0] y, logic [PT_W-1:0] z);
        t_in p;
        p.point_x = x;
        p.point_y = y;
        p.point_z = z;
        pending_points.push_back(p);
    endtask

    function automatic logic [PT_W-1:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return PT_W'($urandom);
            1: return PT_W'($signed($urandom_range(0, 4096)) - 2048);
            2: return PT_W'($urandom_range(0, 65535));
            default: return PT_W'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        if ($urandom_range(0, 2) == 0) return COEF_W'($urandom);
        return COEF_W'($signed($urandom_range(0, 8192)) - 4096);
    endfunction

    task automatic random_points(int count);
        repeat (count) add_point(rand_coord(), rand_coord(), rand_coord());
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_wen   = 1'b0;
        i_cfg_index = REG_ROW_X;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_stall = 1'b0;
        cur_row_x = '0;
        cur_row_y = '0;
        cur_row_w = '0;
        cur_width  = 14'd1920;
        cur_height = 14'd1080;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset rows: everything is hidden with zero clip values
        add_point(24'h7FFFFF, 24'h800000, 24'h000100);
        drain();

        // identity-like setup: clip = (x, y), w = z
        write_reg(REG_ROW_X, {16'h0000, 16'h0000, 16'h0000, 16'h1000});
        write_reg(REG_ROW_Y, {16'h0000, 16'h0000, 16'h1000, 16'h0000});
        write_reg(REG_ROW_W, {16'h0000, 16'h1000, 16'h0000, 16'h0000});
        write_reg(REG_WIDTH, 64'd1920);
        write_reg(REG_HEIGHT, 64'd1080);
        write_reg(IDX_UNUSED, '1);
        add_point(24'h000000, 24'h000000, 24'h000100);
        add_point(24'h000080, 24'hFFFF80, 24'h000100);
        add_point(24'h000100, 24'h000100, 24'h000100);
        add_point(24'h000100, 24'h000100, 24'h000000);
        add_point(24'h000100, 24'hFFFF00, 24'hFFFF00);
        add_point(24'h7FFFFF, 24'h800000, 24'h000001);
        add_point(24'h800000, 24'h7FFFFF, 24'h000001);
        add_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        add_point(24'h800000, 24'h800000, 24'h800000);
        add_point(24'h7FFFFF, 24'h800000, 24'h800000);
        add_point(24'h000003, 24'hFFFFFD, 24'h000007);
        add_point(24'h123456, 24'hABCDEF, 24'h000001);
        add_point(24'h555555, 24'hAAAAAA, 24'h2AAAAA);
        drain();

        // zero, one and 8192-pixel viewport sizes
        write_reg(REG_WIDTH, 64'd0);
        write_reg(REG_HEIGHT, 64'd8192);
        add_point(24'h000100, 24'h000040, 24'h000200);
        add_point(24'h7FFFFF, 24'h800000, 24'h000001);
        drain();
        write_reg(REG_WIDTH, 64'd8192);
        write_reg(REG_HEIGHT, 64'd1);
        add_point(24'h000100, 24'h000040, 24'h000200);
        add_point(24'hFFFF00, 24'h7FFFFF, 24'h000100);
        drain();

        // random phases; the w row mostly leans on z so points are visible
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_ROW_X, {rand_coef(), rand_coef(), rand_coef(), rand_coef()});
            write_reg(REG_ROW_Y, {rand_coef(), rand_coef(), rand_coef(), rand_coef()});
            if (ph == 3)
                write_reg(REG_ROW_W, {$urandom, $urandom});
            else
                write_reg(REG_ROW_W, {rand_coef(), 16'($urandom_range(256, 8192)),
                                      16'($urandom_range(0, 255)), 16'($urandom_range(0, 255))});
            write_reg(REG_WIDTH, ph == 0 ? 64'd1 : 64'($urandom_range(1, 8192)));
            write_reg(REG_HEIGHT, ph == 1 ? 64'd8192 : 64'($urandom_range(1, 8192)));
            if (ph == 3) quiet = 1'b1;
            random_points(200);
            drain();
        end

        $display("Projected %0d points (%0d hidden, %0d saturated) over several matrix",
                 n_in, n_hidden, n_sat);
        $display("and viewport settings with random stalls on both sides, %0d checked",
                 n_out);
        if (n_err == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
